FILE: sv/tsse_pkg.sv
// shared types and constants for the text screen shadow engine
`default_nettype none
package tsse_pkg;
  localparam int MaxCols  = 128;
  localparam int MaxLines = 64;
  localparam int ColW     = $clog2(MaxCols);
  localparam int LineW    = $clog2(MaxLines);
  localparam int AddrW    = ColW + LineW;

  localparam logic [3:0] ActGoto = 4'd0, ActAttr = 4'd1, ActPut = 4'd2, ActIns = 4'd3,
    ActDel = 4'd4, ActEol = 4'd5, ActLdel = 4'd6, ActLins = 4'd7, ActSup = 4'd8,
    ActSdn = 4'd9, ActBlank = 4'd10, ActRead = 4'd11;

  localparam logic [3:0] CmdNone = 4'd0, CmdBs = 4'd1, CmdGoto = 4'd2, CmdChar = 4'd3,
    CmdCins = 4'd4, CmdCdel = 4'd5, CmdEol = 4'd6, CmdLdel = 4'd7, CmdLins = 4'd8,
    CmdSup = 4'd9, CmdSdn = 4'd10;

  localparam logic [1:0] RegCols = 2'd0, RegLines = 2'd1, RegAttr = 2'd2, RegCaps = 2'd3;

  localparam logic [7:0] BlankChar = 8'hFF;
  localparam logic [7:0] BlankAttr = 8'h00;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] InsAttr   = 8'hFF;

  // one memory request from the sequencer
  typedef struct packed {
    logic             rd;
    logic [AddrW-1:0] raddr;
    logic             wr;
    logic [AddrW-1:0] waddr;
    logic [15:0]      wdata;
  } mem_req_t;
endpackage
`default_nettype wire

FILE: sv/tsse_ram.sv
// cell store: one write port, one registered read port
`default_nettype none
module tsse_ram (
  input  wire logic               clk_i,
  input  wire tsse_pkg::mem_req_t req_i,
  output logic [15:0]             rdata_o
);
  import tsse_pkg::*;
  logic [15:0] mem [1 << AddrW];
  always_ff @(posedge clk_i) begin
    if (req_i.wr) mem[req_i.waddr] <= req_i.wdata;
    if (req_i.rd) rdata_o <= mem[req_i.raddr];
  end
endmodule
`default_nettype wire

FILE: sv/text_screen_shadow_engine.sv
// text screen shadow engine top level: sequencer, registers and output stage
// usage:
//   input words arrive on in_valid_i / in_stall_o, one word per action;
//   result words leave on out_valid_o / out_stall_i, one or two per action,
//   the final one flagged by last_o.
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// sequencing:
//   cursor, attribute, put and unknown actions go from decide to emit, which loads
//   the result once the output register is free; read waits for the store data first;
//   the next word is taken in the idle state after emit. character ops copy one cell
//   as a read state then a write state; line ops and scrolls copy row by row the same
//   way, and a scroll without its capability falls back to one or two line ops;
//   blank writes one cell a cycle. one action at a time.
// reset:
//   after reset a clearing pass writes char 0xFF attr 0x00 into all
//   MaxLines*MaxCols cells, during which no word is accepted.
// stall:
//   a result waits in the output register while the receiver stalls;
//   the next action may be accepted meanwhile, its results wait their turn.
`default_nettype none
module text_screen_shadow_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [7:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [3:0]        action_i,
  input  wire logic [6:0]        target_col_i,
  input  wire logic [5:0]        target_line_i,
  input  wire logic [5:0]        region_bottom_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [7:0]        new_attr_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [3:0]             term_cmd_o,
  output logic                   done_res_o,
  output logic signed [7:0]      cursor_col_o,
  output logic signed [6:0]      cursor_line_o,
  output logic [7:0]             cell_char_o,
  output logic [7:0]             cell_attr_o,
  output logic                   last_o
);
  import tsse_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StDecide, StCopyRd, StCopyWr, StFill, StReadWait, StEmit, StNext
  } state_e;

  // one pass over memory: copy rows (or cells) by direction where needed, then fill a span
  state_e state_q;
  logic [7:0] cols_q, normal_q, caps_q, pend_q;
  logic [6:0] lines_q;
  logic signed [7:0] ccol_q;
  logic signed [6:0] cline_q;
  logic [3:0] act_q;
  logic [6:0] tcol_q;
  logic [5:0] tline_q, bot_q;
  logic [7:0] ch_q;
  logic [AddrW:0] clr_q;

  // copy job: lines lo..hi, up (dst=i, src=i+1) or down (dst=i, src=i-1)
  logic       cp_row_q;      // row copy vs in-row cell copy
  logic       cp_up_q;
  logic [7:0] cp_i_q, cp_end_q; // row or column index, current and stop
  logic [7:0] cp_c_q;        // column within row copy
  logic [5:0] cp_line_q;     // fixed line for cell copy
  logic [7:0] fl_c_q, fl_cend_q;   // fill columns
  logic [5:0] fl_l_q, fl_lend_q;   // fill lines
  logic [15:0] fl_val_q;
  logic        fl_multi_q;
  // result plan
  logic [3:0] r_cmd_q; logic r_done_q; logic [15:0] r_cell_q;
  logic       second_q;     // a second line op is pending
  logic       sec_ins_q;    // kind of the next line op: insert
  logic [5:0] sec_line_q;
  logic       r_last_q;

  // output register
  logic ov_q; logic [3:0] o_cmd_q; logic o_done_q, o_last_q;
  logic signed [7:0] o_col_q; logic signed [6:0] o_line_q; logic [15:0] o_cell_q;

  mem_req_t req;
  logic [15:0] rdata;
  tsse_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));

  logic [7:0] nc; logic [6:0] nl;
  assign nc = (cols_q == 8'd0) ? 8'd1 : ((cols_q > 8'(MaxCols)) ? 8'(MaxCols) : cols_q);
  assign nl = (lines_q == 7'd0) ? 7'd1 : ((lines_q > 7'(MaxLines)) ? 7'(MaxLines) : lines_q);

  logic cur_ok;
  assign cur_ok = !ccol_q[7] && !cline_q[6] && ({1'b0, ccol_q[6:0]} < nc) &&
                  ({1'b0, cline_q[5:0]} < nl);

  function automatic logic [AddrW-1:0] adr(input logic [7:0] l, input logic [7:0] c);
    return {l[LineW-1:0], c[ColW-1:0]};
  endfunction

  logic accept;
  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;

  // addresses for the current copy step
  logic [7:0] src_l, src_c, dst_l, dst_c;
  always_comb begin
    if (cp_row_q) begin
      dst_l = cp_i_q; dst_c = cp_c_q;
      src_l = cp_up_q ? cp_i_q + 8'd1 : cp_i_q - 8'd1; src_c = cp_c_q;
    end else begin
      dst_l = {2'b0, cp_line_q}; dst_c = cp_i_q;
      src_l = {2'b0, cp_line_q}; src_c = cp_up_q ? cp_i_q + 8'd1 : cp_i_q - 8'd1;
    end
  end

  // next row or column index of the copy walk
  logic [7:0] cp_next;
  assign cp_next = cp_up_q ? cp_i_q + 8'd1 : cp_i_q - 8'd1;

  always_comb begin
    req = '0;
    case (state_q)
      StClear: begin
        req.wr = 1'b1; req.waddr = clr_q[AddrW-1:0]; req.wdata = {BlankChar, BlankAttr};
      end
      StCopyRd: begin req.rd = 1'b1; req.raddr = adr(src_l, src_c); end
      StCopyWr: begin req.wr = 1'b1; req.waddr = adr(dst_l, dst_c); req.wdata = rdata; end
      StFill: begin
        req.wr = 1'b1; req.waddr = adr({2'b0, fl_l_q}, fl_c_q); req.wdata = fl_val_q;
      end
      StDecide: begin
        req.rd = (act_q == ActRead);
        req.raddr = adr({2'b0, tline_q}, {1'b0, tcol_q});
        req.wr = (act_q == ActPut) && cur_ok;
        req.waddr = adr({1'b0, cline_q}, ccol_q);
        req.wdata = {ch_q, pend_q};
      end
      default: ;
    endcase
  end

  logic o_free;
  assign o_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0;
      cols_q <= 8'd80; lines_q <= 7'd25; normal_q <= 8'd7; caps_q <= 8'hFF; pend_q <= 8'd7;
      ccol_q <= -8'sd1; cline_q <= -7'sd1; ov_q <= 1'b0; second_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCols:  cols_q <= cfg_data_i;
          RegLines: lines_q <= cfg_data_i[6:0];
          RegAttr:  normal_q <= cfg_data_i;
          RegCaps:  caps_q <= cfg_data_i;
          default: ;
        endcase
      end
      // a taken result frees the register unless a new one is loaded now
      if (ov_q && !out_stall_i && state_q != StEmit) ov_q <= 1'b0;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AddrW+1)'((1 << AddrW) - 1)) state_q <= StIdle;
        end
        StIdle: if (accept) begin
          act_q <= action_i; tcol_q <= target_col_i; tline_q <= target_line_i;
          bot_q <= region_bottom_i; ch_q <= char_code_i;
          if (action_i == ActAttr) pend_q <= new_attr_i;
          // default result plan
          r_cmd_q <= CmdNone; r_done_q <= 1'b0; r_cell_q <= '0; r_last_q <= 1'b1;
          fl_multi_q <= 1'b0;
          state_q <= StDecide;
        end
        StDecide: begin
          case (act_q)
            ActGoto: begin : g
              logic [7:0] c; logic [6:0] l;
              c = ({1'b0, tcol_q} < nc) ? {1'b0, tcol_q} : nc - 8'd1;
              l = ({1'b0, tline_q} < nl) ? {1'b0, tline_q} : nl - 7'd1;
              r_done_q <= 1'b1;
              state_q <= StEmit;
              if (cline_q == l && ccol_q == c) r_cmd_q <= CmdNone;
              else if (cline_q == l && !ccol_q[7] && ccol_q - c == 8'd1 && caps_q[0]) begin
                ccol_q <= c; r_cmd_q <= CmdBs;
              end else begin
                ccol_q <= c; cline_q <= l; r_cmd_q <= CmdGoto;
              end
            end
            ActAttr: begin r_done_q <= 1'b1; state_q <= StEmit; end
            ActPut: begin
              state_q <= StEmit;
              if (cur_ok) begin
                r_cmd_q <= CmdChar; r_done_q <= 1'b1;
                if (ccol_q + 8'd1 >= nc) begin ccol_q <= -8'sd1; cline_q <= -7'sd1; end
                else ccol_q <= ccol_q + 8'sd1;
              end
            end
            ActIns, ActDel, ActEol: begin
              if (cur_ok && ((act_q == ActIns && caps_q[1]) || (act_q == ActDel && caps_q[2])
                  || (act_q == ActEol && caps_q[3]))) begin
                r_done_q <= 1'b1;
                cp_row_q <= 1'b0; cp_line_q <= cline_q[5:0];
                fl_l_q <= cline_q[5:0]; fl_lend_q <= cline_q[5:0];
                case (act_q)
                  ActIns: begin
                    r_cmd_q <= CmdCins; cp_up_q <= 1'b0;
                    cp_i_q <= nc - 8'd1; cp_end_q <= ccol_q;
                    fl_c_q <= ccol_q; fl_cend_q <= ccol_q; fl_val_q <= {SpaceChar, InsAttr};
                    state_q <= (nc - 8'd1 > ccol_q) ? StCopyRd : StFill;
                  end
                  ActDel: begin
                    r_cmd_q <= CmdCdel; cp_up_q <= 1'b1;
                    cp_i_q <= ccol_q; cp_end_q <= nc - 8'd1;
                    fl_c_q <= nc - 8'd1; fl_cend_q <= nc - 8'd1;
                    fl_val_q <= {SpaceChar, normal_q};
                    state_q <= (ccol_q < nc - 8'd1) ? StCopyRd : StFill;
                  end
                  default: begin
                    r_cmd_q <= CmdEol; fl_c_q <= ccol_q; fl_cend_q <= nc - 8'd1;
                    fl_val_q <= {SpaceChar, normal_q}; state_q <= StFill;
                  end
                endcase
              end else state_q <= StEmit;
            end
            ActLdel, ActLins: begin
              if ({1'b0, tline_q} < nl) begin
                second_q <= 1'b0; sec_ins_q <= (act_q == ActLins);
                sec_line_q <= tline_q; state_q <= StNext;
              end else state_q <= StEmit;
            end
            ActSup, ActSdn: begin
              if (tline_q <= bot_q && {1'b0, bot_q} < nl) begin
                if ((act_q == ActSup && caps_q[6]) || (act_q == ActSdn && caps_q[7])) begin
                  r_done_q <= 1'b1; cp_row_q <= 1'b1; cp_c_q <= '0;
                  fl_c_q <= '0; fl_cend_q <= nc - 8'd1; fl_val_q <= {SpaceChar, normal_q};
                  if (act_q == ActSup) begin
                    r_cmd_q <= CmdSup; cp_up_q <= 1'b1;
                    cp_i_q <= {2'b0, tline_q}; cp_end_q <= {2'b0, bot_q};
                    fl_l_q <= bot_q; fl_lend_q <= bot_q;
                  end else begin
                    r_cmd_q <= CmdSdn; cp_up_q <= 1'b0;
                    cp_i_q <= {2'b0, bot_q}; cp_end_q <= {2'b0, tline_q};
                    fl_l_q <= tline_q; fl_lend_q <= tline_q;
                  end
                  state_q <= (tline_q != bot_q) ? StCopyRd : StFill;
                end else if (act_q == ActSup) begin
                  sec_ins_q <= 1'b0; sec_line_q <= tline_q;
                  second_q <= ({1'b0, bot_q} < nl - 7'd1);
                  state_q <= StNext;
                end else begin
                  if ({1'b0, bot_q} < nl - 7'd1) begin
                    sec_ins_q <= 1'b0; sec_line_q <= bot_q; second_q <= 1'b1;
                  end else begin
                    sec_ins_q <= 1'b1; sec_line_q <= tline_q; second_q <= 1'b0;
                  end
                  state_q <= StNext;
                end
              end else state_q <= StEmit;
            end
            ActBlank: begin
              r_done_q <= 1'b1; fl_c_q <= '0; fl_cend_q <= nc - 8'd1;
              fl_l_q <= '0; fl_lend_q <= 6'(nl - 7'd1); fl_multi_q <= 1'b1;
              fl_val_q <= {BlankChar, BlankAttr}; state_q <= StFill;
            end
            ActRead: begin
              // every 7 bit column and 6 bit line lies inside the store
              r_done_q <= 1'b1; state_q <= StReadWait;
            end
            default: state_q <= StEmit;
          endcase
        end
        StNext: begin
          // start one line op at sec_line_q; result flagged last unless another follows
          r_last_q <= !second_q;
          fl_multi_q <= 1'b0;
          if ((sec_ins_q && caps_q[5]) || (!sec_ins_q && caps_q[4])) begin
            r_done_q <= 1'b1; r_cmd_q <= sec_ins_q ? CmdLins : CmdLdel;
            cp_row_q <= 1'b1; cp_c_q <= '0; cp_up_q <= !sec_ins_q;
            fl_c_q <= '0; fl_cend_q <= nc - 8'd1; fl_val_q <= {SpaceChar, normal_q};
            if (sec_ins_q) begin
              cp_i_q <= {1'b0, nl - 7'd1}; cp_end_q <= {2'b0, sec_line_q};
              fl_l_q <= sec_line_q; fl_lend_q <= sec_line_q;
              state_q <= ({1'b0, sec_line_q} != nl - 7'd1) ? StCopyRd : StFill;
            end else begin
              cp_i_q <= {2'b0, sec_line_q}; cp_end_q <= {1'b0, nl - 7'd1};
              fl_l_q <= 6'(nl - 7'd1); fl_lend_q <= 6'(nl - 7'd1);
              state_q <= ({1'b0, sec_line_q} != nl - 7'd1) ? StCopyRd : StFill;
            end
          end else begin
            r_done_q <= 1'b0; r_cmd_q <= CmdNone; state_q <= StEmit;
          end
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr: begin
          if (cp_row_q && cp_c_q != nc - 8'd1) begin
            cp_c_q <= cp_c_q + 8'd1;
            state_q <= StCopyRd;
          end else begin
            cp_c_q <= '0;
            cp_i_q <= cp_next;
            state_q <= (cp_next == cp_end_q) ? StFill : StCopyRd;
          end
        end
        StFill: begin
          if (fl_c_q != fl_cend_q) fl_c_q <= fl_c_q + 8'd1;
          else if (fl_multi_q && fl_l_q != fl_lend_q) begin
            fl_c_q <= '0; fl_l_q <= fl_l_q + 6'd1;
          end else state_q <= StEmit;
        end
        StReadWait: begin r_cell_q <= rdata; state_q <= StEmit; end
        StEmit: if (o_free) begin
          ov_q <= 1'b1; o_cmd_q <= r_cmd_q; o_done_q <= r_done_q; o_last_q <= r_last_q;
          o_col_q <= ccol_q; o_line_q <= cline_q; o_cell_q <= r_cell_q;
          if (!r_last_q) begin
            // second op of a fallback scroll
            second_q <= 1'b0; sec_ins_q <= 1'b1;
            sec_line_q <= (act_q == ActSup) ? bot_q : tline_q;
            state_q <= StNext;
          end else state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign term_cmd_o    = o_cmd_q;
  assign done_res_o    = o_done_q;
  assign cursor_col_o  = o_col_q;
  assign cursor_line_o = o_line_q;
  assign cell_char_o   = o_cell_q[15:8];
  assign cell_attr_o   = o_cell_q[7:0];
  assign last_o        = o_last_q;

  // a held result may not change under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(o_cmd_q) && $stable(o_last_q))
    else $error("result changed under stall");
  // no word is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> in_stall_o)
    else $error("input taken while clearing");
  // a fresh result is only loaded when the register was free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit && ov_q && out_stall_i |=> state_q == StEmit)
    else $error("result overwritten");
endmodule
`default_nettype wire

FILE: sim/text_screen_shadow_engine_test.sv
// self-checking testbench for the text screen shadow engine
`default_nettype none
module text_screen_shadow_engine_test;
  import tsse_pkg::*;

  // capability bit positions in reg_caps
  localparam int CapBs = 0, CapCins = 1, CapCdel = 2, CapEol = 3;
  localparam int CapLdel = 4, CapLins = 5, CapSup = 6, CapSdn = 7;
  localparam int CycleLimit = 20000000;

  typedef struct {
    logic [3:0] action;
    logic [6:0] col;
    logic [5:0] line;
    logic [5:0] bottom;
    logic [7:0] chr;
    logic [7:0] attr;
  } action_word_t;

  typedef struct {
    logic [3:0] cmd;
    logic       done;
    logic [7:0] ccol;
    logic [6:0] cline;
    logic [7:0] cch;
    logic [7:0] cat;
    logic       last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] action_i = '0;
  logic [6:0] target_col_i = '0;
  logic [5:0] target_line_i = '0;
  logic [5:0] region_bottom_i = '0;
  logic [7:0] char_code_i = '0;
  logic [7:0] new_attr_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] term_cmd_o;
  logic done_res_o;
  logic signed [7:0] cursor_col_o;
  logic signed [6:0] cursor_line_o;
  logic [7:0] cell_char_o;
  logic [7:0] cell_attr_o;
  logic last_o;

  text_screen_shadow_engine dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the screen state
  logic [7:0] shadow_ch [MaxLines][MaxCols];
  logic [7:0] shadow_at [MaxLines][MaxCols];
  int cur_col, cur_line;
  logic [7:0] pend_attr;
  logic [7:0] reg_cols;
  logic [6:0] reg_lines;
  logic [7:0] reg_attr;
  logic [7:0] reg_caps;

  action_word_t pending_words[$];
  result_word_t expected_words[$];
  int mismatches = 0;

  function automatic int used_cols();
    if (reg_cols < 1) return 1;
    if (reg_cols > MaxCols) return MaxCols;
    return int'(reg_cols);
  endfunction

  function automatic int used_lines();
    if (reg_lines < 1) return 1;
    if (reg_lines > MaxLines) return MaxLines;
    return int'(reg_lines);
  endfunction

  task automatic expect_word(logic [3:0] cmd, int done, int cch, int cat);
    result_word_t r;
    r.cmd = cmd;
    r.done = done[0];
    r.ccol = cur_col[7:0];
    r.cline = cur_line[6:0];
    r.cch = cch[7:0];
    r.cat = cat[7:0];
    r.last = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic copy_row(int dst, int src);
    for (int i = 0; i < used_cols(); i++) begin
      shadow_ch[dst][i] = shadow_ch[src][i];
      shadow_at[dst][i] = shadow_at[src][i];
    end
  endtask

  task automatic clear_row(int l);
    for (int i = 0; i < used_cols(); i++) begin
      shadow_ch[l][i] = SpaceChar;
      shadow_at[l][i] = reg_attr;
    end
  endtask

  task automatic delete_row(int l, output bit ok);
    ok = reg_caps[CapLdel];
    if (ok) begin
      for (int i = l; i < used_lines() - 1; i++) copy_row(i, i + 1);
      clear_row(used_lines() - 1);
    end
  endtask

  task automatic insert_row(int l, output bit ok);
    ok = reg_caps[CapLins];
    if (ok) begin
      for (int i = used_lines() - 1; i > l; i--) copy_row(i, i - 1);
      clear_row(l);
    end
  endtask

  // works out the result words of one accepted action word
  task automatic apply_action(action_word_t w);
    int nc, nl, c, l, top, bot;
    bit cur_ok, ok;
    nc = used_cols();
    nl = used_lines();
    top = int'(w.line);
    bot = int'(w.bottom);
    cur_ok = cur_col >= 0 && cur_line >= 0 && cur_col < nc && cur_line < nl;
    case (w.action)
      ActGoto: begin
        c = (w.col < nc) ? int'(w.col) : nc - 1;
        l = (w.line < nl) ? int'(w.line) : nl - 1;
        if (cur_line == l && cur_col == c) begin
          expect_word(CmdNone, 1, 0, 0);
        end else if (cur_line == l && cur_col >= 0 && cur_col - c == 1 && reg_caps[CapBs]) begin
          cur_col = c;
          expect_word(CmdBs, 1, 0, 0);
        end else begin
          cur_col = c;
          cur_line = l;
          expect_word(CmdGoto, 1, 0, 0);
        end
      end
      ActAttr: begin
        pend_attr = w.attr;
        expect_word(CmdNone, 1, 0, 0);
      end
      ActPut: begin
        if (!cur_ok) begin
          expect_word(CmdNone, 0, 0, 0);
        end else begin
          shadow_ch[cur_line][cur_col] = w.chr;
          shadow_at[cur_line][cur_col] = pend_attr;
          // writing the last column leaves the cursor unknown
          if (cur_col + 1 >= nc) begin
            cur_col = -1;
            cur_line = -1;
          end else begin
            cur_col++;
          end
          expect_word(CmdChar, 1, 0, 0);
        end
      end
      ActIns: begin
        if (!cur_ok || !reg_caps[CapCins]) begin
          expect_word(CmdNone, 0, 0, 0);
        end else begin
          for (int i = nc - 1; i > cur_col; i--) begin
            shadow_ch[cur_line][i] = shadow_ch[cur_line][i - 1];
            shadow_at[cur_line][i] = shadow_at[cur_line][i - 1];
          end
          shadow_ch[cur_line][cur_col] = SpaceChar;
          shadow_at[cur_line][cur_col] = InsAttr;
          expect_word(CmdCins, 1, 0, 0);
        end
      end
      ActDel: begin
        if (!cur_ok || !reg_caps[CapCdel]) begin
          expect_word(CmdNone, 0, 0, 0);
        end else begin
          for (int i = cur_col; i < nc - 1; i++) begin
            shadow_ch[cur_line][i] = shadow_ch[cur_line][i + 1];
            shadow_at[cur_line][i] = shadow_at[cur_line][i + 1];
          end
          shadow_ch[cur_line][nc - 1] = SpaceChar;
          shadow_at[cur_line][nc - 1] = reg_attr;
          expect_word(CmdCdel, 1, 0, 0);
        end
      end
      ActEol: begin
        if (!cur_ok || !reg_caps[CapEol]) begin
          expect_word(CmdNone, 0, 0, 0);
        end else begin
          for (int i = cur_col; i < nc; i++) begin
            shadow_ch[cur_line][i] = SpaceChar;
            shadow_at[cur_line][i] = reg_attr;
          end
          expect_word(CmdEol, 1, 0, 0);
        end
      end
      ActLdel: begin
        ok = 0;
        if (top < nl) delete_row(top, ok);
        if (ok) expect_word(CmdLdel, 1, 0, 0);
        else expect_word(CmdNone, 0, 0, 0);
      end
      ActLins: begin
        ok = 0;
        if (top < nl) insert_row(top, ok);
        if (ok) expect_word(CmdLins, 1, 0, 0);
        else expect_word(CmdNone, 0, 0, 0);
      end
      ActSup: begin
        if (top > bot || bot >= nl) begin
          expect_word(CmdNone, 0, 0, 0);
        end else if (reg_caps[CapSup]) begin
          for (int i = top; i < bot; i++) copy_row(i, i + 1);
          clear_row(bot);
          expect_word(CmdSup, 1, 0, 0);
        end else begin
          // no scroll: delete at top, then insert at bottom if not the last line
          delete_row(top, ok);
          if (ok) expect_word(CmdLdel, 1, 0, 0);
          else expect_word(CmdNone, 0, 0, 0);
          if (bot < nl - 1) begin
            insert_row(bot, ok);
            if (ok) expect_word(CmdLins, 1, 0, 0);
            else expect_word(CmdNone, 0, 0, 0);
          end
        end
      end
      ActSdn: begin
        if (top > bot || bot >= nl) begin
          expect_word(CmdNone, 0, 0, 0);
        end else if (reg_caps[CapSdn]) begin
          for (int i = bot; i > top; i--) copy_row(i, i - 1);
          clear_row(top);
          expect_word(CmdSdn, 1, 0, 0);
        end else begin
          if (bot < nl - 1) begin
            delete_row(bot, ok);
            if (ok) expect_word(CmdLdel, 1, 0, 0);
            else expect_word(CmdNone, 0, 0, 0);
          end
          insert_row(top, ok);
          if (ok) expect_word(CmdLins, 1, 0, 0);
          else expect_word(CmdNone, 0, 0, 0);
        end
      end
      ActBlank: begin
        for (int i = 0; i < nl; i++)
          for (int j = 0; j < nc; j++) begin
            shadow_ch[i][j] = BlankChar;
            shadow_at[i][j] = BlankAttr;
          end
        expect_word(CmdNone, 1, 0, 0);
      end
      ActRead: begin
        // every 7 bit column and 6 bit line lies inside the store
        expect_word(CmdNone, 1, int'(shadow_ch[w.line][w.col]),
                    int'(shadow_at[w.line][w.col]));
      end
      default: begin
        expect_word(CmdNone, 0, 0, 0);
      end
    endcase
    expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  // driver: bursts of words with random gaps between them
  action_word_t drv_word;
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_action(drv_word);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          drv_word = pending_words.pop_front();
          action_i <= drv_word.action;
          target_col_i <= drv_word.col;
          target_line_i <= drv_word.line;
          region_bottom_i <= drv_word.bottom;
          char_code_i <= drv_word.chr;
          new_attr_i <= drv_word.attr;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: free, light or heavy stretches
  int stall_mode = 0;
  int stall_span = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(10, 80);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word cmd=%0d", term_cmd_o);
      end else begin
        want = expected_words.pop_front();
        if (term_cmd_o !== want.cmd || done_res_o !== want.done ||
            cursor_col_o !== want.ccol || cursor_line_o !== want.cline ||
            cell_char_o !== want.cch || cell_attr_o !== want.cat || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp cmd=%0d done=%0d col=%0d line=%0d ch=%h at=%h last=%0d",
                      " / got cmd=%0d done=%0d col=%0d line=%0d ch=%h at=%h last=%0d"},
                     want.cmd, want.done, $signed(want.ccol), $signed(want.cline), want.cch,
                     want.cat, want.last, term_cmd_o, done_res_o, cursor_col_o,
                     cursor_line_o, cell_char_o, cell_attr_o, last_o);
        end
      end
    end
  end

  // run limit, generous for the clearing pass and full screen line ops
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic action_word_t make_word(logic [3:0] a, int c, int l, int b,
                                             int ch, int at);
    action_word_t w;
    w.action = a;
    w.col = c[6:0];
    w.line = l[5:0];
    w.bottom = b[5:0];
    w.chr = ch[7:0];
    w.attr = at[7:0];
    return w;
  endfunction

  // random word: mostly well formed for the current screen, some noise
  function automatic action_word_t random_word();
    action_word_t w;
    int nc, nl;
    nc = used_cols();
    nl = used_lines();
    w.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
    w.col = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, nc - 1));
    w.line = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, nl - 1));
    w.bottom = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(int'(w.line) % nl, nl - 1));
    w.chr = 8'($urandom_range(0, 255));
    w.attr = 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      RegCols: reg_cols = data;
      RegLines: reg_lines = data[6:0];
      RegAttr: reg_attr = data;
      default: reg_caps = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] cols, logic [6:0] lines, logic [7:0] attr,
                           logic [7:0] caps, int count);
    wait_idle();
    write_reg(RegCols, cols);
    write_reg(RegLines, {1'b0, lines});
    write_reg(RegAttr, attr);
    write_reg(RegCaps, caps);
    // one word in five on average is a goto followed by three puts
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_words.push_back(make_word(ActGoto, $urandom_range(0, used_cols() - 1),
                                          $urandom_range(0, used_lines() - 1), 0, 0, 0));
        for (int k = 0; k < 3; k++)
          pending_words.push_back(make_word(ActPut, 0, 0, 0, $urandom_range(0, 255), 0));
      end else begin
        pending_words.push_back(random_word());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxLines; i++)
      for (int j = 0; j < MaxCols; j++) begin
        shadow_ch[i][j] = BlankChar;
        shadow_at[i][j] = BlankAttr;
      end
    cur_col = -1;
    cur_line = -1;
    reg_cols = 8'd80;
    reg_lines = 7'd25;
    reg_attr = 8'd7;
    reg_caps = 8'hFF;
    pend_attr = 8'd7;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset configuration
    pending_words.push_back(make_word(ActPut, 0, 0, 0, 8'h41, 0));    // unknown cursor
    pending_words.push_back(make_word(ActIns, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActDel, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActEol, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActGoto, 127, 63, 0, 0, 0));    // saturates
    pending_words.push_back(make_word(ActGoto, 79, 24, 0, 0, 0));     // same place
    pending_words.push_back(make_word(ActGoto, 78, 24, 0, 0, 0));     // backspace
    pending_words.push_back(make_word(ActAttr, 0, 0, 0, 0, 8'hFF));
    pending_words.push_back(make_word(ActPut, 0, 0, 0, 8'h00, 0));
    pending_words.push_back(make_word(ActPut, 0, 0, 0, 8'hFF, 0));    // last column
    pending_words.push_back(make_word(ActGoto, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActPut, 0, 0, 0, 8'h5A, 0));
    pending_words.push_back(make_word(ActIns, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActDel, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActEol, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActRead, 1, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActRead, 127, 63, 0, 0, 0));
    pending_words.push_back(make_word(ActLdel, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(ActLins, 0, 24, 0, 0, 0));
    pending_words.push_back(make_word(ActLdel, 0, 30, 0, 0, 0));      // beyond screen
    pending_words.push_back(make_word(ActSup, 0, 2, 5, 0, 0));
    pending_words.push_back(make_word(ActSdn, 0, 0, 24, 0, 0));
    pending_words.push_back(make_word(ActSup, 0, 5, 2, 0, 0));        // reversed region
    pending_words.push_back(make_word(ActSdn, 0, 3, 40, 0, 0));       // bottom off screen
    pending_words.push_back(make_word(ActBlank, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(4'd15, 0, 0, 0, 0, 0));         // unused action

    // scroll fallbacks on a small screen, then the extremes
    run_phase(8'd16, 7'd8, 8'hAA, 8'h3F, 10);
    run_phase(8'd16, 7'd8, 8'h55, 8'h1F, 5);
    run_phase(8'd16, 7'd8, 8'h33, 8'h2F, 5);
    run_phase(8'd1, 7'd1, 8'h00, 8'h00, 6);
    run_phase(8'd0, 7'd0, 8'hFF, 8'h0F, 4);
    run_phase(8'd200, 7'd127, 8'hFF, 8'hFF, 3);
    run_phase(8'd128, 7'd64, 8'h01, 8'hC0, 3);
    run_phase(8'd20, 7'd10, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 10);
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
